// ===== rtl/vnth_pkg.sv =====
`timescale 1ns / 1ps

package vnth_pkg;

  // One coordinate in, one height and class out.
  typedef struct packed {
    logic [7:0] cell_x;
    logic [7:0] cell_y;
  } vnth_in_t;

  typedef struct packed {
    logic signed [8:0] height;
    logic [1:0]        terrain_class;
  } vnth_out_t;

  typedef enum logic [1:0] {
    CLASS_ROCK     = 2'd0,
    CLASS_PLAIN    = 2'd1,
    CLASS_FOREST   = 2'd2,
    CLASS_HIGHLAND = 2'd3
  } vnth_class_e;

  // Lattice hash multipliers and the second octave salt.
  localparam logic [31:0] HASH_PX     = 32'd374761393;
  localparam logic [31:0] HASH_PY     = 32'd668265263;
  localparam logic [31:0] HASH_MIX    = 32'd1274126177;
  localparam logic [31:0] OCTAVE_SALT = 32'h5bf03635;
  localparam logic [31:0] SEED_RESET  = 32'd1;

  // Reciprocals of the lattice size 6: x*171 >> 10 is exact below 256,
  // n*683 >> 12 is exact up to 1275.
  localparam logic [15:0] RECIP6_Q10 = 16'd171;
  localparam logic [20:0] RECIP6_Q12 = 21'd683;
  localparam logic [7:0]  LATTICE    = 8'd6;

  // Island falloff near the map border.
  localparam int unsigned EDGE_BAND = 5;
  localparam logic [6:0]  EDGE_DROP = 7'd22;

  // Class band limits.
  localparam logic signed [8:0] BAND_PLAIN    = 9'sd40;
  localparam logic signed [8:0] BAND_FOREST   = 9'sd140;
  localparam logic signed [8:0] BAND_HIGHLAND = 9'sd178;
  localparam logic signed [8:0] BAND_PEAK     = 9'sd220;

endpackage

// ===== rtl/value_noise_terrain_height.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in        input      in_valid_i, in_stall_o   in_data_i  (cell_x, cell_y)
// out       output     out_valid_o, out_stall_i out_data_o (height, terrain_class)
// cfg       input      cfg_valid_i, cfg_ready_o cfg_data_i (world_seed)
//
// One coordinate is taken every cycle while in_stall_o is low; each result passes
// through the six register stages: divide and edge distance, hash
// sums, hash multipliers, horizontal blend, vertical blend and octave mix,
// falloff and class. Reset empties the pipeline and sets world_seed to 1.
// A stall on the output holds only the stages that are full up to the first
// empty one; earlier bubbles keep filling, and cfg_ready_o is always high.
module value_noise_terrain_height import vnth_pkg::*; #(
  parameter int unsigned MAP_WIDTH  = 64,
  parameter int unsigned MAP_HEIGHT = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  vnth_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output vnth_out_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam logic signed [9:0] WIDTH_S  = 10'(MAP_WIDTH);
  localparam logic signed [9:0] HEIGHT_S = 10'(MAP_HEIGHT);
  localparam logic signed [9:0] BAND_S   = 10'(EDGE_BAND);

  // Quotient by the lattice size through a reciprocal multiply.
  function automatic logic [5:0] div6(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * RECIP6_Q10;
    return p[15:10];
  endfunction

  // Distance to the nearer border along one axis, may go negative.
  function automatic logic signed [9:0] edge_dist(input logic [7:0] v,
                                                  input logic signed [9:0] size);
    logic signed [9:0] vs;
    logic signed [9:0] rest;
    vs   = $signed({2'b00, v});
    rest = size - vs;
    return (vs < rest) ? vs : rest - 10'sd1;
  endfunction

  // Lattice hash up to the xor shift; only the low 24 bits feed the multiply.
  function automatic logic [23:0] hash_pre(input logic [6:0] px, input logic [6:0] py,
                                           input logic [31:0] salt);
    logic [31:0] h;
    logic [31:0] m;
    h = {25'd0, px} * HASH_PX + {25'd0, py} * HASH_PY + salt;
    m = h ^ (h >> 13);
    return m[23:0];
  endfunction

  // Final hash multiply; bits 23:16 of the product are the lattice value.
  function automatic logic [7:0] hash_val(input logic [23:0] m);
    logic [23:0] p;
    p = m * HASH_MIX[23:0];
    return p[23:16];
  endfunction

  // lo + (hi - lo) * f / 6 with truncation toward zero.
  function automatic logic [7:0] lerp6(input logic [7:0] lo, input logic [7:0] hi,
                                       input logic [2:0] f);
    logic signed [8:0]  diff;
    logic signed [11:0] prod;
    logic [10:0]        mag;
    logic [20:0]        scaled;
    logic [7:0]         q;
    logic [9:0]         sum;
    diff   = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod   = $signed(12'(diff)) * $signed({9'd0, f});
    mag    = prod[11] ? 11'(-prod) : prod[10:0];
    scaled = {10'd0, mag} * RECIP6_Q12;
    q      = scaled[19:12];
    sum    = prod[11] ? ({2'b00, lo} - {2'b00, q}) : ({2'b00, lo} + {2'b00, q});
    return sum[7:0];
  endfunction

  // Configuration register.
  logic [31:0] seed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (cfg_valid_i) begin
      seed_q <= cfg_data_i;
    end
  end

  // Pipeline valid bits and per-stage load enables.
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en0, en1, en2, en3, en4, en5;

  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign in_stall_o = !en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 0: lattice cell and offset, octave cell, edge falloff amount.
  logic [5:0] gx0_q, gy0_q, gx_d, gy_d;
  logic [2:0] fx0_q, fy0_q, fx_d, fy_d;
  logic [6:0] hx0_q, hy0_q;
  logic [6:0] drop0_q, drop_d;
  logic [7:0] fx_full, fy_full;
  logic signed [9:0] ex, ey, edge_min;
  logic [2:0] steps;

  always_comb begin
    gx_d    = div6(in_data_i.cell_x);
    gy_d    = div6(in_data_i.cell_y);
    fx_full = in_data_i.cell_x - 8'({2'b00, gx_d} * LATTICE);
    fy_full = in_data_i.cell_y - 8'({2'b00, gy_d} * LATTICE);
    fx_d    = fx_full[2:0];
    fy_d    = fy_full[2:0];
    ex       = edge_dist(in_data_i.cell_x, WIDTH_S);
    ey       = edge_dist(in_data_i.cell_y, HEIGHT_S);
    edge_min = (ex < ey) ? ex : ey;
    if (edge_min < 10'sd0) begin
      edge_min = 10'sd0;
    end
    steps  = 3'(BAND_S - edge_min);
    drop_d = (edge_min < BAND_S) ? 7'({4'd0, steps} * EDGE_DROP) : 7'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      gx0_q   <= gx_d;
      gy0_q   <= gy_d;
      fx0_q   <= fx_d;
      fy0_q   <= fy_d;
      hx0_q   <= in_data_i.cell_x[7:1];
      hy0_q   <= in_data_i.cell_y[7:1];
      drop0_q <= drop_d;
    end
  end

  // Stage 1: hash sums and xor shift for the four corners and the octave point.
  logic [23:0] ma1_q, mb1_q, mc1_q, md1_q, mf1_q;
  logic [2:0]  fx1_q, fy1_q;
  logic [6:0]  drop1_q;
  logic [6:0]  gx_lo, gy_lo, gx_hi, gy_hi;

  always_comb begin
    gx_lo = {1'b0, gx0_q};
    gy_lo = {1'b0, gy0_q};
    gx_hi = gx_lo + 7'd1;
    gy_hi = gy_lo + 7'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ma1_q   <= hash_pre(gx_lo, gy_lo, seed_q);
      mb1_q   <= hash_pre(gx_hi, gy_lo, seed_q);
      mc1_q   <= hash_pre(gx_lo, gy_hi, seed_q);
      md1_q   <= hash_pre(gx_hi, gy_hi, seed_q);
      mf1_q   <= hash_pre(hx0_q, hy0_q, seed_q ^ OCTAVE_SALT);
      fx1_q   <= fx0_q;
      fy1_q   <= fy0_q;
      drop1_q <= drop0_q;
    end
  end

  // Stage 2: hash multiplies give the 8-bit lattice values.
  logic [7:0] a2_q, b2_q, c2_q, d2_q, f2_q;
  logic [2:0] fx2_q, fy2_q;
  logic [6:0] drop2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      a2_q    <= hash_val(ma1_q);
      b2_q    <= hash_val(mb1_q);
      c2_q    <= hash_val(mc1_q);
      d2_q    <= hash_val(md1_q);
      f2_q    <= hash_val(mf1_q);
      fx2_q   <= fx1_q;
      fy2_q   <= fy1_q;
      drop2_q <= drop1_q;
    end
  end

  // Stage 3: blend along x on the top and bottom rows.
  logic [7:0] top3_q, bot3_q, f3_q;
  logic [2:0] fy3_q;
  logic [6:0] drop3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      top3_q  <= lerp6(a2_q, b2_q, fx2_q);
      bot3_q  <= lerp6(c2_q, d2_q, fx2_q);
      f3_q    <= f2_q;
      fy3_q   <= fy2_q;
      drop3_q <= drop2_q;
    end
  end

  // Stage 4: blend along y, then mix in the octave at one quarter.
  logic [7:0] base4_q;
  logic [6:0] drop4_q;
  logic [7:0] vert;
  logic [9:0] mix;

  always_comb begin
    vert = lerp6(top3_q, bot3_q, fy3_q);
    mix  = {2'b00, vert} + {1'b0, vert, 1'b0} + {2'b00, f3_q};
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      base4_q <= mix[9:2];
      drop4_q <= drop3_q;
    end
  end

  // Stage 5: border falloff and class bands into the output register.
  vnth_out_t   out_q;
  logic signed [8:0] hgt;
  vnth_class_e cls;

  always_comb begin
    hgt = $signed({1'b0, base4_q}) - $signed({2'b00, drop4_q});
    if (hgt < BAND_PLAIN) begin
      cls = CLASS_ROCK;
    end else if (hgt < BAND_FOREST) begin
      cls = CLASS_PLAIN;
    end else if (hgt < BAND_HIGHLAND) begin
      cls = CLASS_FOREST;
    end else if (hgt < BAND_PEAK) begin
      cls = CLASS_HIGHLAND;
    end else begin
      cls = CLASS_ROCK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      out_q.height        <= hgt;
      out_q.terrain_class <= cls;
    end
  end

  assign out_valid_o = v5_q;
  assign out_data_o  = out_q;

endmodule
